[design/block_idct_8x8_top_defines.svh]
// Assertion macros used by the checker file.
`ifndef BLOCK_IDCT_8X8_TOP_DEFINES_SVH
`define BLOCK_IDCT_8X8_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define IDCT8_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define IDCT8_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/idct8_pkg.sv]
// ----------------------------------------------------------------------------
// idct8_pkg
// Shared types, widths and the cosine table of the 8x8 inverse DCT.
// ----------------------------------------------------------------------------
package idct8_pkg;

  localparam int N       = 8;
  localparam int IDX_W   = 3;
  localparam int ADDR_W  = 6;
  localparam int CIN_W   = 15;
  localparam int CST_W   = 16;
  localparam int T_W     = 22;
  localparam int COEF_W  = 12;
  localparam int ACC_W   = 37;
  localparam int PIX_W   = 8;
  localparam int REM_W   = 4;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PASS1,
    ST_PASS2,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] coef_rd_addr;
    logic [IDX_W-1:0]  t_rd_row;
    logic              acc_en;
    logic              acc_clr;
    logic              pass2;
    logic [IDX_W-1:0]  coef_k;
    logic [IDX_W-1:0]  coef_row;
    logic              t_wr;
    logic [IDX_W-1:0]  t_wr_row;
    logic              pix_ld;
    logic              pix_shift;
  } ctrl_t;

  localparam logic signed [COEF_W-1:0] COEF [N][N] = '{
    '{ 12'sd1448,  12'sd1448,  12'sd1448,  12'sd1448,
       12'sd1448,  12'sd1448,  12'sd1448,  12'sd1448 },
    '{ 12'sd2008,  12'sd1702,  12'sd1137,  12'sd399,
      -12'sd399,  -12'sd1137, -12'sd1702, -12'sd2008 },
    '{ 12'sd1892,  12'sd783,  -12'sd783,  -12'sd1892,
      -12'sd1892, -12'sd783,   12'sd783,   12'sd1892 },
    '{ 12'sd1702, -12'sd399,  -12'sd2008, -12'sd1137,
       12'sd1137,  12'sd2008,  12'sd399,  -12'sd1702 },
    '{ 12'sd1448, -12'sd1448, -12'sd1448,  12'sd1448,
       12'sd1448, -12'sd1448, -12'sd1448,  12'sd1448 },
    '{ 12'sd1137, -12'sd2008,  12'sd399,   12'sd1702,
      -12'sd1702, -12'sd399,   12'sd2008, -12'sd1137 },
    '{ 12'sd783,  -12'sd1892,  12'sd1892, -12'sd783,
      -12'sd783,   12'sd1892, -12'sd1892,  12'sd783 },
    '{ 12'sd399,  -12'sd1137,  12'sd1702, -12'sd2008,
       12'sd2008, -12'sd1702,  12'sd1137, -12'sd399 }
  };

endpackage

[design/idct8_cell.sv]
// ----------------------------------------------------------------------------
// idct8_cell
// One multiply-accumulate cell with its slot of the pixel shift chain.
// ----------------------------------------------------------------------------
module idct8_cell (
  input  logic                                   clk,
  input  logic                                   acc_en,
  input  logic                                   acc_clr,
  input  logic signed [idct8_pkg::T_W-1:0]       operand,
  input  logic signed [idct8_pkg::COEF_W-1:0]    coef,
  input  logic                                   pix_ld,
  input  logic                                   pix_shift,
  input  logic        [idct8_pkg::PIX_W-1:0]     pix_in,
  output logic signed [idct8_pkg::ACC_W-1:0]     acc,
  output logic        [idct8_pkg::PIX_W-1:0]     pix
);

  logic signed [idct8_pkg::T_W+idct8_pkg::COEF_W-1:0] prod_raw;
  logic signed [idct8_pkg::ACC_W-1:0] prod;
  logic signed [idct8_pkg::ACC_W-1:0] base;
  logic        [idct8_pkg::PIX_W-1:0] clipped;

  // 22 x 12 signed product, then sign-extended to the accumulator width.
  assign prod_raw = operand * coef;
  assign prod     = idct8_pkg::ACC_W'(prod_raw);
  assign base     = acc_clr ? '0 : acc;

  // Floor shift by 16, then clip to 0..255.
  always_comb begin
    if (acc[idct8_pkg::ACC_W-1]) begin
      clipped = '0;
    end else if (acc[idct8_pkg::ACC_W-2:24] != '0) begin
      clipped = '1;
    end else begin
      clipped = acc[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (acc_en) begin
      acc <= base + prod;
    end
    if (pix_ld) begin
      pix <= clipped;
    end else if (pix_shift) begin
      pix <= pix_in;
    end
  end

endmodule

[design/idct8_seq.sv]
// ----------------------------------------------------------------------------
// idct8_seq
// Sequencer: load count, pass and row counters, read pipeline, drain count.
// ----------------------------------------------------------------------------
module idct8_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_last,
  output idct8_pkg::ctrl_t  ctrl
);

  idct8_pkg::state_t state, state_next;

  logic [idct8_pkg::ADDR_W-1:0] load_count;
  logic [idct8_pkg::IDX_W-1:0]  row, k;
  logic [idct8_pkg::REM_W-1:0]  remain;
  logic                         v1, p2_1, v2, p2_2, last2;
  logic [idct8_pkg::IDX_W-1:0]  k1, row1, row2;
  logic                         issue, in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      idct8_pkg::ST_LOAD: begin
        if (in_acc && load_count == '1) state_next = idct8_pkg::ST_PASS1;
      end
      idct8_pkg::ST_PASS1: begin
        if (row == '1 && k == '1) state_next = idct8_pkg::ST_PASS2;
      end
      idct8_pkg::ST_PASS2: begin
        if (k == '1) state_next = idct8_pkg::ST_DRAIN;
      end
      idct8_pkg::ST_DRAIN: begin
        if (out_acc && remain == idct8_pkg::REM_W'(1)) begin
          state_next = (row == '1) ? idct8_pkg::ST_LOAD : idct8_pkg::ST_PASS2;
        end
      end
      default: state_next = idct8_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready          = (state == idct8_pkg::ST_LOAD);
    issue             = (state == idct8_pkg::ST_PASS1) || (state == idct8_pkg::ST_PASS2);
    out_valid         = (remain != '0);
    out_last          = (row == '1) && (remain == idct8_pkg::REM_W'(1));
    ctrl.wr_en        = in_acc;
    ctrl.wr_addr      = load_count;
    ctrl.coef_rd_addr = {row, k};
    ctrl.t_rd_row     = k;
    ctrl.acc_en       = v1;
    ctrl.acc_clr      = (k1 == '0);
    ctrl.pass2        = p2_1;
    ctrl.coef_k       = k1;
    ctrl.coef_row     = row1;
    ctrl.t_wr         = v2 && !p2_2 && last2;
    ctrl.t_wr_row     = row2;
    ctrl.pix_ld       = v2 && p2_2 && last2;
    ctrl.pix_shift    = out_acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= idct8_pkg::ST_LOAD;
      load_count <= '0;
      row        <= '0;
      k          <= '0;
      remain     <= '0;
      v1         <= 1'b0;
      v2         <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc) load_count <= load_count + 1'b1;
      if (state == idct8_pkg::ST_PASS1) begin
        k <= k + 1'b1;
        if (k == '1) row <= row + 1'b1;
      end else if (state == idct8_pkg::ST_PASS2) begin
        k <= k + 1'b1;
      end else if (state == idct8_pkg::ST_DRAIN && out_acc &&
                   remain == idct8_pkg::REM_W'(1)) begin
        row <= row + 1'b1;
      end
      if (ctrl.pix_ld) begin
        remain <= idct8_pkg::REM_W'(idct8_pkg::N);
      end else if (out_acc) begin
        remain <= remain - 1'b1;
      end
      v1 <= issue;
      v2 <= v1;
    end
  end

  // Pipeline tags follow the registered memory read.
  always_ff @(posedge clk) begin
    k1    <= k;
    row1  <= row;
    p2_1  <= (state == idct8_pkg::ST_PASS2);
    row2  <= row1;
    p2_2  <= p2_1;
    last2 <= (k1 == '1);
  end

endmodule

[design/block_idct_8x8_top.sv]
// ----------------------------------------------------------------------------
// block_idct_8x8_top
// Integer 8x8 inverse DCT built on a row of eight multiply-accumulate cells.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------
//  input    | in_valid / in_ready  | coefficient (15b signed)
//  output   | out_valid / out_ready| pixel (8b), last (1b)
//
// Input: one request per cycle while loading, 64 coefficients for a block. The first
// pass broadcasts one coefficient to the eight column cells each cycle; its last
// row is written to the intermediate store while the second pass runs. For each
// output row the second pass accumulates into the cells, then loads and drains
// the row of pixels through the output chain; each cell holds one MAC.
// Reset clears the sequencer only; an output stall holds chain and sequencer.
// ----------------------------------------------------------------------------
module block_idct_8x8_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [idct8_pkg::CIN_W-1:0]  coefficient,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic        [idct8_pkg::PIX_W-1:0]  pixel,
  output logic                                last
);

  localparam int N  = idct8_pkg::N;
  localparam int TW = idct8_pkg::T_W;

  idct8_pkg::ctrl_t ctrl;

  // Coefficient store: one request per entry, one read per cycle.
  logic signed [idct8_pkg::CST_W-1:0] coef_mem [2**idct8_pkg::ADDR_W];
  logic signed [idct8_pkg::CST_W-1:0] coef_q;

  // Intermediate store: one row of T per entry, written whole by the cells.
  logic [N*TW-1:0] t_mem [N];
  logic [N*TW-1:0] t_q;
  logic [N*TW-1:0] t_wdata;

  logic signed [idct8_pkg::ACC_W-1:0] acc  [N];
  logic        [idct8_pkg::PIX_W-1:0] pix  [N];
  logic        [idct8_pkg::PIX_W-1:0] link [N+1];

  idct8_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_last  (last),
    .ctrl      (ctrl)
  );

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      coef_mem[ctrl.wr_addr] <= idct8_pkg::CST_W'(coefficient);
    end
    coef_q <= coef_mem[ctrl.coef_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctrl.t_wr) begin
      t_mem[ctrl.t_wr_row] <= t_wdata;
    end
    t_q <= t_mem[ctrl.t_rd_row];
  end

  // Chain end feeds zeros; the head of the chain drives the pixel port.
  assign link[N] = '0;
  assign pixel   = pix[0];

  for (genvar j = 0; j < N; j++) begin : g_cell
    logic signed [TW-1:0]                  operand;
    logic signed [idct8_pkg::COEF_W-1:0]   coef;

    // Pass one: column j of C against a broadcast coefficient.
    // Pass two: row entry of C against column j of T.
    assign operand = ctrl.pass2 ? $signed(t_q[j*TW +: TW]) : TW'(coef_q);
    assign coef    = ctrl.pass2 ? idct8_pkg::COEF[ctrl.coef_k][ctrl.coef_row]
                                : idct8_pkg::COEF[ctrl.coef_k][j];
    // Floor shift by 8; the sum always fits in 30 signed bits.
    assign t_wdata[j*TW +: TW] = acc[j][TW+7:8];
    assign link[j] = pix[j];

    idct8_cell u_cell (
      .clk       (clk),
      .acc_en    (ctrl.acc_en),
      .acc_clr   (ctrl.acc_clr),
      .operand   (operand),
      .coef      (coef),
      .pix_ld    (ctrl.pix_ld),
      .pix_shift (ctrl.pix_shift),
      .pix_in    (link[j+1]),
      .acc       (acc[j]),
      .pix       (pix[j])
    );
  end

endmodule

[design/idct8_checker.sv]
// ----------------------------------------------------------------------------
// idct8_checker
// Port-level checks of the inverse DCT block, bound to the top level.
// ----------------------------------------------------------------------------
`include "block_idct_8x8_top_defines.svh"

module idct8_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [idct8_pkg::PIX_W-1:0]        pixel,
  input logic                               last
);

  `IDCT8_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pixel) && $stable(last), "output request dropped or changed while stalled")
  `IDCT8_ASSERT_IMP(a_no_overlap, in_ready, !out_valid, "input taken while pixels pending")
  `IDCT8_ASSERT_NXT(a_last_reload, out_valid && out_ready && last, in_ready && !out_valid, "block did not return to loading after last pixel")
  `IDCT8_ASSERT_NXT(a_last_once, out_valid && out_ready && last, !last, "last marked twice")

endmodule

bind block_idct_8x8_top idct8_checker u_idct8_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .pixel     (pixel),
  .last      (last)
);
